// ===== design/kchs_pkg.sv =====
// shared types and constants for the k-mer chained hash set
`timescale 1ns / 1ps

package kchs_pkg;

    // defaults for the top-level parameters
    localparam int KMER_LEN_DEF     = 31;
    localparam int HASH_BITS_DEF    = 12;
    localparam int POOL_ENTRIES_DEF = 4096;

    // fixed field widths
    localparam int KEY_W     = 62;
    localparam int POS_W     = 32;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 8;
    localparam int KIND_W    = 2;

    // bit positions of the result flags in m_tdata
    localparam int FOUND_BIT = 0;
    localparam int FULL_BIT  = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD,
        ST_CMP,
        ST_MTF,
        ST_INS,
        ST_CLR,
        ST_DONE
    } state_t;

endpackage

// ===== design/kmer_chained_hash_set.sv =====
// top level: chained hash set of packed k-mers with move-to-front on hit
`timescale 1ns / 1ps

// Set of packed k-mers in a separately chained hash table held in block memories:
// one bucket-head memory (2^HASH_BITS words) and an entry pool of POOL_ENTRIES
// keys, positions and links. Each beat carries its kind in s_tuser (lookup,
// insert if absent, clear) and gets one result beat with found and pool_full.
// Items are handled one at a time. A lookup or insert reads its bucket head, then
// walks the chain serially, comparing one entry at a time. A hit past the chain
// head is moved to the front; an insert that misses links a new entry at the head.
// A clear sweeps the bucket heads at one per cycle. After reset the same sweep runs
// with s_tready low. A result waiting on m_tready holds the next item
// in its final cycle.
module kmer_chained_hash_set #(
    parameter int KMER_LEN     = kchs_pkg::KMER_LEN_DEF,
    parameter int HASH_BITS    = kchs_pkg::HASH_BITS_DEF,
    parameter int POOL_ENTRIES = kchs_pkg::POOL_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kchs_pkg::S_DATA_W-1:0] s_tdata,  // kmer_key[61:0], position[93:62]
    input  logic [kchs_pkg::KIND_W-1:0]   s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kchs_pkg::M_DATA_W-1:0] m_tdata   // found[0], pool_full[1]
);
    import kchs_pkg::*;

    localparam int KEY_BITS = (2 * KMER_LEN < KEY_W) ? 2 * KMER_LEN : KEY_W;
    localparam int NCHUNK   = (2 * KMER_LEN + HASH_BITS - 1) / HASH_BITS;
    localparam int PAD_W    = (NCHUNK * HASH_BITS > KEY_W) ? NCHUNK * HASH_BITS : KEY_W;
    localparam int BUCKETS  = 1 << HASH_BITS;
    localparam int PTR_W    = $clog2(POOL_ENTRIES + 1);
    localparam int IDX_W    = $clog2(POOL_ENTRIES);
    localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(POOL_ENTRIES);
    localparam logic [KEY_W-1:0] KEY_MASK  =
        (KEY_BITS == KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
    } entry_t;

    // memories
    logic [PTR_W-1:0] bucket_mem [BUCKETS];
    entry_t           entry_mem  [POOL_ENTRIES];
    logic [PTR_W-1:0] link_mem   [POOL_ENTRIES];

    state_t               state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [HASH_BITS-1:0] bucket_reg, bucket_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     cur_reg, cur_next;
    logic [PTR_W-1:0]     prev_reg, prev_next;
    logic [PTR_W-1:0]     used_reg, used_next;
    logic [HASH_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic                 found_reg, found_next;
    logic                 full_reg, full_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic                 m_full_reg, m_full_next;

    // memory read data and write controls
    logic [PTR_W-1:0]     head_q;
    logic [KEY_W-1:0]     ekey_q;
    logic [PTR_W-1:0]     link_q;
    logic [PTR_W-1:0]     rd_ptr;
    logic                 bucket_we;
    logic [HASH_BITS-1:0] bucket_waddr;
    logic [PTR_W-1:0]     bucket_wdata;
    logic                 link_we;
    logic [PTR_W-1:0]     link_waddr;
    logic [PTR_W-1:0]     link_wdata;
    logic                 entry_we;

    logic [KEY_W-1:0]     in_key;
    logic [PAD_W-1:0]     key_pad;
    logic [HASH_BITS-1:0] in_hash;

    // xor fold of the masked key
    always_comb begin
        in_key  = s_tdata[KEY_W-1:0] & KEY_MASK;
        key_pad = PAD_W'(in_key);
        in_hash = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            in_hash = in_hash ^ key_pad[i*HASH_BITS +: HASH_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        head_q <= bucket_mem[bucket_reg];
        ekey_q <= entry_mem[rd_ptr[IDX_W-1:0]].key;
        link_q <= link_mem[rd_ptr[IDX_W-1:0]];
        if (bucket_we) begin
            bucket_mem[bucket_waddr] <= bucket_wdata;
        end
        if (link_we) begin
            link_mem[link_waddr[IDX_W-1:0]] <= link_wdata;
        end
        if (entry_we) begin
            entry_mem[used_reg[IDX_W-1:0]] <= '{pos: pos_reg, key: key_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            used_reg      <= '0;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
        end
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        bucket_reg  <= bucket_next;
        head_reg    <= head_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
        m_found_reg <= m_found_next;
        m_full_reg  <= m_full_next;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        bucket_next    = bucket_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        used_next      = used_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_full_next    = m_full_reg;
        rd_ptr         = link_q;
        bucket_we      = 1'b0;
        bucket_waddr   = bucket_reg;
        bucket_wdata   = cur_reg;
        link_we        = 1'b0;
        link_waddr     = prev_reg;
        link_wdata     = link_q;
        entry_we       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    key_next    = in_key;
                    pos_next    = s_tdata[KEY_W +: POS_W];
                    bucket_next = in_hash;
                    found_next  = 1'b0;
                    full_next   = 1'b0;
                    case (s_tuser)
                        KIND_LOOKUP, KIND_INSERT: state_next = ST_HEAD_RD;
                        KIND_CLEAR: begin
                            clr_cnt_next   = '0;
                            clr_reply_next = 1'b1;
                            used_next      = '0;
                            state_next     = ST_CLR;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                head_next = head_q;
                cur_next  = head_q;
                prev_next = NULL_PTR;
                rd_ptr    = head_q;
                if (head_q != NULL_PTR) begin
                    state_next = ST_CMP;
                end else if (kind_reg == KIND_INSERT) begin
                    state_next = ST_INS;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                if (ekey_q == key_reg) begin
                    found_next = 1'b1;
                    if (prev_reg == NULL_PTR) begin
                        state_next = ST_DONE;
                    end else begin
                        // unlink: prev skips over the hit entry
                        link_we    = 1'b1;
                        state_next = ST_MTF;
                    end
                end else if (link_q == NULL_PTR) begin
                    if (kind_reg == KIND_INSERT) begin
                        state_next = ST_INS;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_q;
                end
            end
            ST_MTF: begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = head_reg;
                bucket_we  = 1'b1;
                state_next = ST_DONE;
            end
            ST_INS: begin
                if (used_reg >= NULL_PTR) begin
                    full_next = 1'b1;
                end else begin
                    entry_we     = 1'b1;
                    link_we      = 1'b1;
                    link_waddr   = used_reg;
                    link_wdata   = head_reg;
                    bucket_we    = 1'b1;
                    bucket_wdata = used_reg;
                    used_next    = used_reg + PTR_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_CLR: begin
                bucket_we    = 1'b1;
                bucket_waddr = clr_cnt_reg;
                bucket_wdata = NULL_PTR;
                clr_cnt_next = clr_cnt_reg + HASH_BITS'(1);
                if (&clr_cnt_reg) begin
                    clr_reply_next = 1'b0;
                    state_next     = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_full_next  = full_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        m_tdata            = '0;
        m_tdata[FOUND_BIT] = m_found_reg;
        m_tdata[FULL_BIT]  = m_full_reg;
    end

endmodule

// ===== design/kchs_checker.sv =====
// port-level checks for the k-mer chained hash set, bound to the top level
`timescale 1ns / 1ps

module kchs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kchs_pkg::M_DATA_W-1:0] m_tdata
);
    import kchs_pkg::*;

    // a stalled result beat keeps its flags
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an item is never both found and dropped
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[FOUND_BIT] && m_tdata[FULL_BIT]))
        else $error("found and pool_full both set");

    // the bucket sweep after reset keeps the input closed
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // one item at a time: an accepted beat closes the input for the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in progress");

endmodule

bind kmer_chained_hash_set kchs_checker u_kchs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_kmer_chained_hash_set.sv =====
// testbench for the chained k-mer hash set: shadow table, scoreboard and random stream drivers
`timescale 1ns / 1ps

module tb_kmer_chained_hash_set;
    import kchs_pkg::*;

    localparam int KMER_LEN     = KMER_LEN_DEF;
    localparam int HASH_BITS    = HASH_BITS_DEF;
    localparam int POOL_ENTRIES = POOL_ENTRIES_DEF;
    localparam int BUCKETS      = 1 << HASH_BITS;
    localparam int LINK_W       = $clog2(POOL_ENTRIES + 1);
    localparam bit [KEY_W-1:0] KEY_MASK = (2 * KMER_LEN >= KEY_W) ? {KEY_W{1'b1}}
                                        : KEY_W'((64'd1 << (2 * KMER_LEN)) - 64'd1);
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RECENT_DEPTH = 64;

    // shadow copy of the table plus the queue of flags each accepted beat should produce
    class kmer_set_shadow;
        bit [LINK_W-1:0] head [BUCKETS];
        bit [KEY_W-1:0]  ekey [POOL_ENTRIES];
        bit [POS_W-1:0]  epos [POOL_ENTRIES];
        bit [LINK_W-1:0] elink [POOL_ENTRIES];
        int              used;
        bit [1:0]        flags_due [$];   // {pool_full, found}
        int items, hits, drops, clears, ignored, checked, errors;

        function new();
            wipe();
            items = 0; hits = 0; drops = 0; clears = 0;
            ignored = 0; checked = 0; errors = 0;
        endfunction

        function void wipe();
            for (int b = 0; b < BUCKETS; b++) head[b] = LINK_W'(POOL_ENTRIES);
            used = 0;
        endfunction

        static function bit [HASH_BITS-1:0] bucket_of(bit [KEY_W-1:0] key);
            bit [KEY_W-1:0]     rest;
            bit [HASH_BITS-1:0] h;
            rest = key;
            h = '0;
            for (int b = 0; b < 2 * KMER_LEN; b += HASH_BITS) begin
                h ^= rest[HASH_BITS-1:0];
                rest = rest >> HASH_BITS;
            end
            return h;
        endfunction

        // chain walk; a hit below the head is relinked at the head
        function bit probe(bit [KEY_W-1:0] key, bit [HASH_BITS-1:0] bkt);
            int cur;
            int prev;
            int steps;
            cur = head[bkt];
            prev = POOL_ENTRIES;
            steps = 0;
            while (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
                if (ekey[cur] == key) begin
                    if (prev < POOL_ENTRIES) begin
                        elink[prev] = elink[cur];
                        elink[cur] = head[bkt];
                        head[bkt] = cur[LINK_W-1:0];
                    end
                    return 1'b1;
                end
                prev = cur;
                cur = elink[cur];
                steps++;
            end
            return 1'b0;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] raw_key,
                                logic [POS_W-1:0] pos);
            bit [KEY_W-1:0]     key;
            bit [HASH_BITS-1:0] bkt;
            bit                 found;
            bit                 full;
            key = raw_key & KEY_MASK;
            bkt = bucket_of(key);
            found = 1'b0;
            full = 1'b0;
            items++;
            case (kind)
                KIND_LOOKUP: found = probe(key, bkt);
                KIND_INSERT: begin
                    if (probe(key, bkt)) begin
                        found = 1'b1;
                    end else if (used >= POOL_ENTRIES) begin
                        full = 1'b1;
                    end else begin
                        ekey[used] = key;
                        epos[used] = pos;
                        elink[used] = head[bkt];
                        head[bkt] = used[LINK_W-1:0];
                        used++;
                    end
                end
                KIND_CLEAR: begin
                    wipe();
                    clears++;
                end
                default: ignored++;
            endcase
            hits += found;
            drops += full;
            flags_due.push_back({full, found});
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            bit [1:0] want;
            checked++;
            if (flags_due.size() == 0) begin
                $error("result beat with nothing pending: tdata=%h", data);
                errors++;
                return;
            end
            want = flags_due.pop_front();
            if (data[FOUND_BIT] !== want[0]) begin
                $error("found: expected %0d, actual %b", want[0], data[FOUND_BIT]);
                errors++;
            end
            if (data[FULL_BIT] !== want[1]) begin
                $error("pool_full: expected %0d, actual %b", want[1], data[FULL_BIT]);
                errors++;
            end
        endfunction

        function int pending();
            return flags_due.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int src_idle_pct  = 31;
    int sink_idle_pct = 58;

    kmer_set_shadow     shadow;
    bit [KEY_W-1:0]     recent_keys [$];
    bit [HASH_BITS-1:0] hot_bucket [3];

    kmer_chained_hash_set #(
        .KMER_LEN     (KMER_LEN),
        .HASH_BITS    (HASH_BITS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // kmer_key[61:0], position[93:62]
        .s_tuser  (s_tuser),   // kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // found[0], pool_full[1]
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                shadow.note_item(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W+POS_W-1:KEY_W]);
            if (m_tvalid && m_tready)
                shadow.check_result(m_tdata);
        end
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit [KEY_W-1:0] rand_key();
        bit [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KEY_W-1:0];
    endfunction

    // random key forced into a chosen bucket by fixing the low chunk
    function automatic bit [KEY_W-1:0] key_in_bucket(bit [HASH_BITS-1:0] bkt);
        bit [KEY_W-1:0] k;
        k = rand_key();
        k[HASH_BITS-1:0] = '0;
        k[HASH_BITS-1:0] = bkt ^ kmer_set_shadow::bucket_of(k);
        return k;
    endfunction

    function automatic void remember(bit [KEY_W-1:0] key);
        recent_keys.push_back(key);
        if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    endfunction

    function automatic bit [KEY_W-1:0] recent_key();
        return recent_keys[$urandom_range(recent_keys.size() - 1)];
    endfunction

    function automatic bit [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45 && recent_keys.size() > 0) return recent_key();
        if (r < 70) return key_in_bucket(hot_bucket[$urandom_range(2)]);
        if (r < 72) return {KEY_W{r[0]}};
        return rand_key();
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                             logic [POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_W - KEY_W - POS_W){1'b0}}, pos, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        bit [KEY_W-1:0]     ka;
        bit [KEY_W-1:0]     kb;
        bit [KEY_W-1:0]     kc;
        bit [HASH_BITS-1:0] bkt;
        bkt = HASH_BITS'($urandom_range(BUCKETS - 1));
        ka = key_in_bucket(bkt);
        kb = key_in_bucket(bkt);
        kc = key_in_bucket(bkt);
        send_item(KIND_LOOKUP, '0, '0);                 // miss on an empty table
        send_item(KIND_UNUSED, '1, '1);
        send_item(KIND_INSERT, '0, '0);
        send_item(KIND_INSERT, '1, '1);
        send_item(KIND_LOOKUP, '0, $urandom());
        send_item(KIND_LOOKUP, '1, $urandom());
        send_item(KIND_INSERT, '0, $urandom());         // already present
        send_item(KIND_INSERT, ka, $urandom());
        send_item(KIND_INSERT, kb, $urandom());
        send_item(KIND_INSERT, kc, $urandom());
        send_item(KIND_LOOKUP, ka, $urandom());         // tail hit, goes to the front
        send_item(KIND_LOOKUP, ka, $urandom());
        send_item(KIND_LOOKUP, kb, $urandom());
        send_item(KIND_INSERT, kc, $urandom());
        send_item(KIND_LOOKUP, key_in_bucket(bkt), $urandom());  // walks the whole chain
        send_item(KIND_UNUSED, ka, $urandom());
        send_item(KIND_CLEAR, KEY_W'($urandom()), $urandom());
        send_item(KIND_LOOKUP, ka, $urandom());
        send_item(KIND_INSERT, ka, $urandom());
        send_item(KIND_LOOKUP, ka, $urandom());
        remember(ka);
        remember(kb);
        remember(kc);
    endtask

    task automatic run_random(int count);
        int                r;
        logic [KIND_W-1:0] kind;
        bit [KEY_W-1:0]    key;
        bit [POS_W-1:0]    pos;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(999);
            if (r < 15)
                kind = KIND_CLEAR;
            else if (r < 45)
                kind = KIND_UNUSED;
            else if (r < 520)
                kind = KIND_LOOKUP;
            else
                kind = KIND_INSERT;
            key = pick_key();
            r = $urandom_range(19);
            pos = (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
            if (kind == KIND_INSERT) remember(key);
            send_item(kind, key, pos);
        end
    endtask

    initial begin
        shadow = new();
        for (int i = 0; i < 3; i++) hot_bucket[i] = HASH_BITS'($urandom_range(BUCKETS - 1));
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 31;
        sink_idle_pct = 58;
        run_directed();
        run_random(600);

        src_idle_pct  = 58;
        sink_idle_pct = 31;
        run_random(550);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(530);
        s_tvalid <= 1'b0;

        while (shadow.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d beats: %0d hits, %0d clears, %0d unused kinds",
                 shadow.items, shadow.hits, shadow.clears, shadow.ignored);
        $display("%0d inserts dropped on a full pool; checked %0d result beats, %0d mismatches",
                 shadow.drops, shadow.checked, shadow.errors);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
